// ===== src/skset_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted key set.
// No dependencies.
package skset_pkg;

   localparam int KEY_W         = 16;
   localparam int STATUS_W      = 3;
   localparam int COUNT_W       = 6;
   localparam int DEPTH_DEFAULT = 32;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOTFOUND  = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_POST = 3'b100
   } state_type;

endpackage

// ===== src/skset_store.sv =====
`timescale 1ns / 1ps
// Key memory: one write port, one read port with registered read data.
// Depends on skset_pkg.
module skset_store #(
   parameter int DEPTH = skset_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [skset_pkg::KEY_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [skset_pkg::KEY_W-1:0] rd_data
);
   import skset_pkg::*;

   logic [KEY_W-1:0] key_mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/skset_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: streams the store once per item, searching and shifting in place.
// Depends on skset_pkg; drives skset_store.
module skset_ctrl #(
   parameter int DEPTH = skset_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [skset_pkg::KEY_W-1:0]   req_key_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [skset_pkg::STATUS_W-1:0] rsp_status,
   output logic [skset_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [skset_pkg::KEY_W-1:0]   wr_data,
   output logic [AW-1:0]                 rd_addr,
   input  logic [skset_pkg::KEY_W-1:0]   rd_data
);
   import skset_pkg::*;

   state_type          state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   carry_ff, carry_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               shift_ff, shift_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               in_range;
   logic               full;

   assign in_range = idx_ff < count_ff;
   assign full     = count_ff == CW'(DEPTH);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      carry_in      = carry_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(idx_ff);
      wr_data       = key_ff;
      rd_addr       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               key_in   = req_key_id;
               idx_in   = '0;
               shift_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_addr = AW'(idx_ff + CW'(1));
            idx_in  = idx_ff + CW'(1);
            if (cmd_ff == CMD_INSERT) begin
               if (shift_ff) begin
                  wr_en    = 1'b1;
                  wr_data  = carry_ff;
                  carry_in = rd_data;
                  if (!in_range) begin
                     count_in  = count_ff + CW'(1);
                     status_in = ST_INSERTED;
                     state_in  = S_POST;
                  end
               end else if (in_range && rd_data == key_ff) begin
                  status_in = ST_DUPLICATE;
                  state_in  = S_POST;
               end else if (!in_range || rd_data > key_ff) begin
                  if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_POST;
                  end else begin
                     wr_en    = 1'b1;
                     carry_in = rd_data;
                     shift_in = 1'b1;
                     if (!in_range) begin
                        count_in  = count_ff + CW'(1);
                        status_in = ST_INSERTED;
                        state_in  = S_POST;
                     end
                  end
               end
            end else begin
               if (shift_ff) begin
                  if (!in_range) begin
                     count_in  = count_ff - CW'(1);
                     status_in = ST_REMOVED;
                     state_in  = S_POST;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(idx_ff - CW'(1));
                     wr_data = rd_data;
                  end
               end else if (!in_range || rd_data > key_ff) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_POST;
               end else if (rd_data == key_ff) begin
                  shift_in = 1'b1;
               end
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      carry_ff      <= carry_in;
      idx_ff        <= idx_in;
      shift_ff      <= shift_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== src/sorted_key_set_insert_remove.sv =====
`timescale 1ns / 1ps
// Top level of the sorted key set: insert and remove of 16-bit keys.
// Depends on skset_pkg, skset_store and skset_ctrl.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_cmd, req_key_id
//   rsp_     out        rsp_valid/rsp_stall  rsp_status, rsp_entry_count
//
// One pass over the store through its single read port, one entry per cycle, shift
// writes trailing the reads; an insert or a removal walks all count keys held, and a
// duplicate, missing key or full set stops the pass at position p. The result shows
// in the same cycle that the next item can be accepted.
// Reset is synchronous; it empties the set, the memory is not cleared.
// A new item is taken while a result waits under rsp_stall; the next
// result waits in the sequencer until the output register frees.
module sorted_key_set_insert_remove #(
   parameter int DEPTH = skset_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [skset_pkg::KEY_W-1:0]    req_key_id,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [skset_pkg::STATUS_W-1:0] rsp_status,
   output logic [skset_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import skset_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   logic [KEY_W-1:0] rd_data;

   skset_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skset_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key_id      (req_key_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

endmodule

// ===== src/skset_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sorted key set, bound to the top level.
// Depends on skset_pkg and sorted_key_set_insert_remove.
module skset_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [skset_pkg::STATUS_W-1:0] rsp_status,
   input logic [skset_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import skset_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous item still in work");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL)
      else $error("status code out of range");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled result changed");

endmodule

bind sorted_key_set_insert_remove skset_checker u_skset_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);
